[rtl/core/sbs_pkg.sv]
// Shared widths, constants and the sideband type for the segment versus square slab test.
// No dependencies; every other file in rtl/core uses this package.
`default_nettype none

package sbs_pkg;

    localparam int COORD_W = 32;
    localparam int SIZE_W  = 31;
    localparam int NUM_W   = 35;
    localparam int DEN_W   = 34;
    localparam int QUO_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int DIV_LAT = QUO_W + 2;

    localparam logic signed [QUO_W-1:0] T_MAX_Q = 32'sh7FFF_FFFF;
    localparam logic signed [QUO_W-1:0] T_MIN_Q = 32'sh8000_0000;
    localparam logic signed [QUO_W-1:0] ONE_Q   = 32'sh0001_0000;

    typedef struct packed {
        logic valid;
        logic zero_x;
        logic zero_z;
        logic miss;
    } side_t;

endpackage

`default_nettype wire

[rtl/core/sbs_div.sv]
// Pipelined signed Q16.16 divider, one restoring quotient bit per stage, saturating result.
// Depends on sbs_pkg for widths and saturation limits.
`default_nettype none

module sbs_div (
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic signed [sbs_pkg::NUM_W-1:0]      num,
    input  wire logic signed [sbs_pkg::DEN_W-1:0]      den,
    output logic signed [sbs_pkg::QUO_W-1:0]           t
);

    localparam int NW = sbs_pkg::NUM_W;
    localparam int DW = sbs_pkg::DEN_W;
    localparam int QW = sbs_pkg::QUO_W;
    localparam int FW = sbs_pkg::FRAC_W;

    logic [NW-1:0] an;
    logic [DW-1:0] ad;

    logic [DW-1:0] r_reg   [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic [DW-1:0] ad_reg  [QW+1];
    logic [FW-1:0] lo_reg  [QW+1];
    logic          neg_reg [QW+1];
    logic          ovf_reg [QW+1];
    logic signed [QW-1:0] t_reg;
    logic signed [QW-1:0] t_next;

    assign an = num[NW-1] ? NW'(-num) : NW'(num);
    assign ad = den[DW-1] ? DW'(-den) : DW'(den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= DW'(an[NW-1:FW]);
            q_reg[0]   <= '0;
            ad_reg[0]  <= ad;
            lo_reg[0]  <= an[FW-1:0];
            neg_reg[0] <= num[NW-1] ^ den[DW-1];
            ovf_reg[0] <= DW'(an[NW-1:FW]) >= ad;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        localparam int BI = QW - 1 - k;
        logic          nbit;
        logic [DW:0]   trial;
        logic [DW:0]   diff;

        if (BI >= FW)
        begin : g_in
            assign nbit = lo_reg[k][BI-FW];
        end
        else
        begin : g_zero
            assign nbit = 1'b0;
        end

        assign trial = {r_reg[k], nbit};
        assign diff  = trial - {1'b0, ad_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k+1]   <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
                q_reg[k+1]   <= q_reg[k] | (QW'(!diff[DW]) << BI);
                ad_reg[k+1]  <= ad_reg[k];
                lo_reg[k+1]  <= lo_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    always_comb
    begin
        if (neg_reg[QW])
        begin
            if (ovf_reg[QW] || (q_reg[QW] > 32'h8000_0000))
                t_next = sbs_pkg::T_MIN_Q;
            else
                t_next = QW'(-$signed({1'b0, q_reg[QW]}));
        end
        else
        begin
            if (ovf_reg[QW] || q_reg[QW][QW-1])
                t_next = sbs_pkg::T_MAX_Q;
            else
                t_next = $signed(q_reg[QW]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            t_reg <= t_next;
    end

    assign t = t_reg;

endmodule

`default_nettype wire

[rtl/core/segment_box_slab_test_xz.sv]
// Segment versus square obstacle slab test in the x-z plane; one beat in, one hit beat out.
// Depends on sbs_pkg and sbs_div.
// A new segment and box may be taken every cycle; the result leaves after the input register, the four
// 32-stage restoring dividers that form the slab parameters in parallel, and the ordering and hit registers.
// A stall on the output holds the whole pipeline in place, so no beat is lost or repeated.
`default_nettype none

module segment_box_slab_test_xz (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [sbs_pkg::COORD_W-1:0]  start_x,
    input  wire logic signed [sbs_pkg::COORD_W-1:0]  start_z,
    input  wire logic signed [sbs_pkg::COORD_W-1:0]  end_x,
    input  wire logic signed [sbs_pkg::COORD_W-1:0]  end_z,
    input  wire logic signed [sbs_pkg::COORD_W-1:0]  center_x,
    input  wire logic signed [sbs_pkg::COORD_W-1:0]  center_z,
    input  wire logic        [sbs_pkg::SIZE_W-1:0]   box_size,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     hit
);

    localparam int NW = sbs_pkg::NUM_W;
    localparam int DW = sbs_pkg::DEN_W;
    localparam int QW = sbs_pkg::QUO_W;
    localparam int DL = sbs_pkg::DIV_LAT;

    logic en;
    logic out_valid_reg;
    logic hit_reg;
    logic hit_next;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    logic signed [32:0] sx2, sz2, ex2, ez2, cx2, cz2;
    logic signed [33:0] lox2, hix2, loz2, hiz2;
    logic signed [33:0] sx2e, sz2e;
    logic               inside_x, inside_z;

    assign sx2 = {start_x, 1'b0};
    assign sz2 = {start_z, 1'b0};
    assign ex2 = {end_x, 1'b0};
    assign ez2 = {end_z, 1'b0};
    assign cx2 = {center_x, 1'b0};
    assign cz2 = {center_z, 1'b0};
    assign sx2e = {sx2[32], sx2};
    assign sz2e = {sz2[32], sz2};
    assign lox2 = {cx2[32], cx2} - $signed({3'b000, box_size});
    assign hix2 = {cx2[32], cx2} + $signed({3'b000, box_size});
    assign loz2 = {cz2[32], cz2} - $signed({3'b000, box_size});
    assign hiz2 = {cz2[32], cz2} + $signed({3'b000, box_size});
    assign inside_x = (sx2e >= lox2) && (sx2e <= hix2);
    assign inside_z = (sz2e >= loz2) && (sz2e <= hiz2);

    logic signed [NW-1:0] nlox_reg, nhix_reg, nloz_reg, nhiz_reg;
    logic signed [DW-1:0] dx_reg, dz_reg;
    sbs_pkg::side_t       side_reg [DL+1];
    sbs_pkg::side_t       side_next;

    always_comb
    begin
        side_next.valid  = in_valid;
        side_next.zero_x = (ex2 == sx2);
        side_next.zero_z = (ez2 == sz2);
        side_next.miss   = ((ex2 == sx2) && !inside_x) || ((ez2 == sz2) && !inside_z);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nlox_reg <= {lox2[33], lox2} - {sx2e[33], sx2e};
            nhix_reg <= {hix2[33], hix2} - {sx2e[33], sx2e};
            nloz_reg <= {loz2[33], loz2} - {sz2e[33], sz2e};
            nhiz_reg <= {hiz2[33], hiz2} - {sz2e[33], sz2e};
            dx_reg   <= {ex2[32], ex2} - sx2e;
            dz_reg   <= {ez2[32], ez2} - sz2e;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DL; i++)
                side_reg[i] <= '0;
        end
        else if (en)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i <= DL; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    logic signed [QW-1:0] tax, tbx, taz, tbz;

    sbs_div u_div_lox (.clk(clk), .en(en), .num(nlox_reg), .den(dx_reg), .t(tax));
    sbs_div u_div_hix (.clk(clk), .en(en), .num(nhix_reg), .den(dx_reg), .t(tbx));
    sbs_div u_div_loz (.clk(clk), .en(en), .num(nloz_reg), .den(dz_reg), .t(taz));
    sbs_div u_div_hiz (.clk(clk), .en(en), .num(nhiz_reg), .den(dz_reg), .t(tbz));

    logic signed [QW-1:0] txlo_reg, txhi_reg, tzlo_reg, tzhi_reg;
    logic                 ord_valid_reg;
    logic                 ord_miss_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (side_reg[DL].zero_x)
            begin
                txlo_reg <= sbs_pkg::T_MIN_Q;
                txhi_reg <= sbs_pkg::T_MAX_Q;
            end
            else
            begin
                txlo_reg <= (tax > tbx) ? tbx : tax;
                txhi_reg <= (tax > tbx) ? tax : tbx;
            end
            if (side_reg[DL].zero_z)
            begin
                tzlo_reg <= sbs_pkg::T_MIN_Q;
                tzhi_reg <= sbs_pkg::T_MAX_Q;
            end
            else
            begin
                tzlo_reg <= (taz > tbz) ? tbz : taz;
                tzhi_reg <= (taz > tbz) ? taz : tbz;
            end
            ord_miss_reg <= side_reg[DL].miss;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ord_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ord_valid_reg <= side_reg[DL].valid;
            out_valid_reg <= ord_valid_reg;
        end
    end

    logic signed [QW-1:0] lo, hi;

    always_comb
    begin
        lo = (tzlo_reg > txlo_reg) ? tzlo_reg : txlo_reg;
        hi = (tzhi_reg < txhi_reg) ? tzhi_reg : txhi_reg;
        hit_next = !ord_miss_reg && !(txlo_reg > tzhi_reg || tzlo_reg > txhi_reg) &&
                   (hi >= 0) && (lo <= sbs_pkg::ONE_Q);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            hit_reg <= hit_next;
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

    a_miss_no_hit : assert property (@(posedge clk) disable iff (!rst_n)
        en && ord_valid_reg && ord_miss_reg |=> out_valid && !hit)
        else $error("a beat with a zero-direction miss produced a hit");

    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(out_valid) && $stable(hit) && $stable(ord_valid_reg))
        else $error("pipeline moved while the output was stalled");

    a_x_ordered : assert property (@(posedge clk) disable iff (!rst_n)
        ord_valid_reg |-> (txlo_reg <= txhi_reg) && (tzlo_reg <= tzhi_reg))
        else $error("slab interval bounds out of order");

endmodule

`default_nettype wire

[test/tb_segment_box_slab_test_xz.sv]
// Testbench for the segment versus square slab test: random and directed segments and boxes
// are streamed in, and each hit beat is compared with a predictor built into this file.
// Depends on sbs_pkg and segment_box_slab_test_xz.
`timescale 1ns / 100ps

module tb_segment_box_slab_test_xz;

    localparam int  LATENCY   = 37;
    localparam int  CYCLE_CAP = 400000;
    localparam longint T_HI   = 64'sd2147483647;
    localparam longint T_LO   = -64'sd2147483648;
    localparam longint T_ONE  = 64'sd65536;

    typedef struct {
        logic signed [sbs_pkg::COORD_W-1:0] sx, sz, ex, ez, cx, cz;
        logic        [sbs_pkg::SIZE_W-1:0]  size;
    } segment_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [sbs_pkg::COORD_W-1:0] start_x, start_z, end_x, end_z, center_x, center_z;
    logic [sbs_pkg::SIZE_W-1:0] box_size;
    logic out_valid;
    logic out_stall;
    logic hit;

    segment_t pending_segments[$];
    logic     expected_hits[$];
    int       sender_idle_pct;
    int       receiver_idle_pct;
    int       errors;
    int       cycles;
    int       hits_seen;
    int       beats_seen;
    bit       stimulus_done;

    segment_box_slab_test_xz DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .start_x(start_x), .start_z(start_z), .end_x(end_x), .end_z(end_z),
        .center_x(center_x), .center_z(center_z), .box_size(box_size),
        .out_valid(out_valid), .out_stall(out_stall), .hit(hit)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void add_segment(segment_t s);
        begin
            pending_segments.insert(pending_segments.size(), s);
        end
    endfunction

    function automatic longint slab_param(longint num, longint den);
        bit      neg;
        longint  an;
        longint  ad;
        longint  q;
        begin
            neg = (num < 0) != (den < 0);
            an = (num < 0) ? -num : num;
            ad = (den < 0) ? -den : den;
            q = (an <<< 16) / ad;
            if (neg)
                return (q > 64'sd2147483648) ? T_LO : -q;
            return (q > T_HI) ? T_HI : q;
        end
    endfunction

    function automatic bit axis_interval(longint s2, longint e2, longint lo2, longint hi2,
                                         output longint tlo, output longint thi);
        longint d2;
        longint a;
        longint b;
        begin
            d2 = e2 - s2;
            tlo = T_LO;
            thi = T_HI;
            if (d2 == 0)
                return !(s2 < lo2 || s2 > hi2);
            a = slab_param(lo2 - s2, d2);
            b = slab_param(hi2 - s2, d2);
            tlo = (a > b) ? b : a;
            thi = (a > b) ? a : b;
            return 1'b1;
        end
    endfunction

    function automatic logic segment_hits_box(segment_t s);
        longint half;
        longint xlo, xhi, zlo, zhi, lo, hi;
        bit     ok;
        begin
            half = longint'(s.size);
            ok = axis_interval(2 * longint'(s.sx), 2 * longint'(s.ex),
                               2 * longint'(s.cx) - half, 2 * longint'(s.cx) + half, xlo, xhi);
            if (!ok)
                return 1'b0;
            ok = axis_interval(2 * longint'(s.sz), 2 * longint'(s.ez),
                               2 * longint'(s.cz) - half, 2 * longint'(s.cz) + half, zlo, zhi);
            if (!ok || xlo > zhi || zlo > xhi)
                return 1'b0;
            lo = (zlo > xlo) ? zlo : xlo;
            hi = (zhi < xhi) ? zhi : xhi;
            return (hi >= 0 && lo <= T_ONE);
        end
    endfunction

    function automatic logic signed [sbs_pkg::COORD_W-1:0] pick_coord(int span);
        begin
            case ($urandom_range(0, 9))
                0: return $urandom;
                1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                default: return $signed($urandom_range(0, 2 * span)) - span;
            endcase
        end
    endfunction

    function automatic segment_t random_segment();
        segment_t s;
        int       span;
        begin
            span = $urandom_range(0, 3) == 0 ? 32'h3FFF_FFFF : ($urandom_range(1, 40) << 16);
            s.cx = pick_coord(span);
            s.cz = pick_coord(span);
            s.size = sbs_pkg::SIZE_W'($urandom_range(0, 7) == 0 ? $urandom
                                                                : $urandom_range(0, span));
            s.sx = $urandom_range(0, 1) ? s.cx + pick_coord(span) : pick_coord(span);
            s.sz = $urandom_range(0, 1) ? s.cz + pick_coord(span) : pick_coord(span);
            s.ex = $urandom_range(0, 5) == 0 ? s.sx : s.cx + pick_coord(span);
            s.ez = $urandom_range(0, 5) == 0 ? s.sz : s.cz + pick_coord(span);
            if ($urandom_range(0, 19) == 0)
            begin
                s.sx = s.cx + (s.size >> 1);
                s.ex = s.sx;
            end
            return s;
        end
    endfunction

    function automatic segment_t make_segment(int sx, int sz, int ex, int ez, int cx, int cz,
                                              int size);
        segment_t s;
        begin
            s.sx = sx; s.sz = sz; s.ex = ex; s.ez = ez; s.cx = cx; s.cz = cz;
            s.size = size[sbs_pkg::SIZE_W-1:0];
            return s;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_hits.insert(expected_hits.size(),
                                     segment_hits_box(pending_segments.pop_front()));
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_segments.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    start_x  <= pending_segments[0].sx;
                    start_z  <= pending_segments[0].sz;
                    end_x    <= pending_segments[0].ex;
                    end_z    <= pending_segments[0].ez;
                    center_x <= pending_segments[0].cx;
                    center_z <= pending_segments[0].cz;
                    box_size <= pending_segments[0].size;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            cycles <= cycles + 1;
            if (out_valid && !out_stall)
            begin
                beats_seen <= beats_seen + 1;
                if (expected_hits.size() == 0)
                begin
                    $error("hit beat with nothing expected: actual %0b", hit);
                    errors <= errors + 1;
                end
                else
                begin
                    if (hit !== expected_hits[0])
                    begin
                        $error("hit mismatch: expected %0b actual %0b", expected_hits[0], hit);
                        errors <= errors + 1;
                    end
                    hits_seen <= hits_seen + (hit === 1'b1);
                    void'(expected_hits.pop_front());
                end
            end
            out_stall <= $urandom_range(0, 99) < receiver_idle_pct;
        end
    end

    initial
    begin
        int phase;
        int k;
        in_valid = 1'b0;
        out_stall = 1'b0;
        start_x = '0; start_z = '0; end_x = '0; end_z = '0;
        center_x = '0; center_z = '0; box_size = '0;
        sender_idle_pct = 29;
        receiver_idle_pct = 75;
        errors = 0;
        cycles = 0;
        hits_seen = 0;
        beats_seen = 0;
        stimulus_done = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        add_segment(make_segment(-'h50000, 0, 'h50000, 0, 0, 0, 'h20000));
        add_segment(make_segment(-'h50000, 'h10000, 'h50000, 'h10000,
                                 0, 0, 'h20000));
        add_segment(make_segment(-'h50000, 'h10001, 'h50000, 'h10001,
                                 0, 0, 'h20000));
        add_segment(make_segment(0, 0, 0, 0, 0, 0, 0));
        add_segment(make_segment('h10000, 0, 'h10000, 0, 0, 0, 'h20000));
        add_segment(make_segment('h10001, 0, 'h10001, 0, 0, 0, 'h20000));
        add_segment(make_segment(-'h30000, 0, -'h10000, 0, 0, 0, 'h20000));
        add_segment(make_segment(-'h30000, 0, -'h10001, 0, 0, 0, 'h20000));
        add_segment(make_segment(-'h30000, -'h30000, 'h30000, 'h30000,
                                 0, 0, 'h20000));
        add_segment(make_segment('h30000, 'h30000, -'h30000, -'h30000,
                                 0, 0, 'h20000));
        add_segment(make_segment(0, 0, 1, 1, 'h7FFF0000, 'h7FFF0000,
                                 'h7FFFFFFF));
        add_segment(make_segment('h80000000, 'h80000000, 'h7FFFFFFF,
                                 'h7FFFFFFF, 0, 0, 'h7FFFFFFF));
        add_segment(make_segment('h7FFFFFFF, 'h80000000, 'h80000000,
                                 'h7FFFFFFF, 'h80000000, 'h7FFFFFFF, 0));
        add_segment(make_segment(0, 0, 1, 0, 'h10000, 0, 2));
        add_segment(make_segment(-1, -1, -1, -1, -1, -1, 'h7FFFFFFF));
        add_segment(make_segment(0, 'h40000, 0, 'h50000, 0, 0, 'h20000));

        for (phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 75 : 0;
            receiver_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 29 : 0;
            for (k = 0; k < 560; k++)
                add_segment(random_segment());
            while (pending_segments.size() > 0)
                @(posedge clk);
        end
        stimulus_done = 1'b1;
    end

    initial
    begin
        int tail;
        wait (stimulus_done);
        while (expected_hits.size() > 0)
            @(posedge clk);
        for (tail = 0; tail < 4 * LATENCY; tail++)
            @(posedge clk);
        $display("Checked %0d hit beats (%0d hits) from directed edge cases and random",
                 beats_seen, hits_seen);
        $display("segments under three sender and receiver stall mixes in %0d cycles.", cycles);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_CAP)
        begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule

[filelist.f]
rtl/core/sbs_pkg.sv
rtl/core/sbs_div.sv
rtl/core/segment_box_slab_test_xz.sv
test/tb_segment_box_slab_test_xz.sv
